>>> rtl/tnt_pkg.sv
// shared types and constants of the triangle normal and tangent unit
`default_nettype none
package tnt_pkg;

   // width of every payload field on the channels
   localparam int FieldW = 16;
   // fraction bits of the unit vector outputs
   localparam int FracBits = 14;
   // default coordinate width read from each input field
   localparam int CoordWidthDefault = 16;
   // operand width of the shared multiplier
   localparam int MulW = 32;
   // magnitude width after range reduction, below 2^31
   localparam int MagW = 31;
   // quotient bits of the divide, enough for 2^FracBits
   localparam int QuotW = FracBits + 1;
   // last step of the product phase (fourteen products, one drain step)
   localparam int ProdLast = 14;
   // last step of the square phase (three squares, one drain step)
   localparam int SqLast = 3;
   // first step of the root phase, one result bit per step
   localparam int RootFirst = 31;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_SHIFT,
      ST_SQ,
      ST_ROOT,
      ST_DIVINIT,
      ST_DIV,
      ST_DONE
   } tnt_state_type;

endpackage
`default_nettype wire

>>> rtl/triangle_normal_tangent_unit.sv
// top level: triangle face normal and tangent with a shared multiplier and subtractor
//
//  channel | direction | handshake             | item
//  req_    | in        | req_valid / req_stall | one vertex: position and texture coordinate
//  rsp_    | out       | rsp_valid / rsp_stall | unit normal, unit tangent, degenerate flags
//
// the first two corners of a triangle are only stored; the third corner starts
// the products on the shared multiplier, then per vector a range shift, the
// squares, the root steps and the divide steps on the shared subtractor; a zero
// vector skips the shift, the squares, the root and the divide
// synchronous reset clears the sequencer, the corner count and the output valid
// the next item is taken while a finished result waits under rsp_stall; the
// sequencer holds before its writeback only if the previous result is still there
`default_nettype none
module triangle_normal_tangent_unit #(
   parameter int COORD_WIDTH = tnt_pkg::CoordWidthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tnt_pkg::FieldW-1:0]  req_pos_x,
   input  logic [tnt_pkg::FieldW-1:0]  req_pos_y,
   input  logic [tnt_pkg::FieldW-1:0]  req_pos_z,
   input  logic [tnt_pkg::FieldW-1:0]  req_tex_u,
   input  logic [tnt_pkg::FieldW-1:0]  req_tex_v,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tnt_pkg::FieldW-1:0]  rsp_normal_x,
   output logic [tnt_pkg::FieldW-1:0]  rsp_normal_y,
   output logic [tnt_pkg::FieldW-1:0]  rsp_normal_z,
   output logic [tnt_pkg::FieldW-1:0]  rsp_tangent_x,
   output logic [tnt_pkg::FieldW-1:0]  rsp_tangent_y,
   output logic [tnt_pkg::FieldW-1:0]  rsp_tangent_z,
   output logic                        rsp_normal_degenerate,
   output logic                        rsp_tangent_degenerate
);
   import tnt_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int DiffShift = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
   localparam int DiffW = COORD_WIDTH - DiffShift + 1;
   localparam int VecW = 2 * DiffW + 1;
   localparam int RemW = 2 * MulW;
   localparam int DivW = MulW + FracBits;

   // low CW bits of a field as two's complement
   function automatic logic signed [CW-1:0] take_coord(input logic [FieldW-1:0] raw);
      logic [CW+FieldW-1:0] ext;
      ext = {{CW{1'b0}}, raw};
      return ext[CW-1:0];
   endfunction

   // difference with its magnitude scaled down for wide coordinates
   function automatic logic signed [DiffW-1:0] scaled_diff(
      input logic signed [CW-1:0] a,
      input logic signed [CW-1:0] b
   );
      logic signed [CW:0] d;
      logic [CW:0]        m;
      logic [CW:0]        r;
      d = {a[CW-1], a} - {b[CW-1], b};
      m = d[CW] ? (CW+1)'(-d) : d;
      m = m >> DiffShift;
      r = d[CW] ? (CW+1)'(-m) : m;
      return r[DiffW-1:0];
   endfunction

   tnt_state_type state_ff, state_in;
   logic [1:0]  count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept, out_load;

   logic signed [CW-1:0]    cur [5];
   logic signed [CW-1:0]    held_ff [2][5], held_in [2][5];
   logic signed [DiffW-1:0] e0_ff [3], e0_in [3];
   logic signed [DiffW-1:0] e1_ff [3], e1_in [3];
   logic signed [DiffW-1:0] t1_ff, t1_in, b1_ff, b1_in, t2_ff, t2_in, b2_ff, b2_in;
   logic signed [RemW-1:0]  prod_ff, prod_in, acc_ff, acc_in;
   logic signed [VecW-1:0]  vec_ff [7], vec_in [7];
   logic [VecW-1:0]         mag_ff [3], mag_in [3];
   logic [MagW-1:0]         mag31 [3];
   logic                    neg_ff [3], neg_in [3];
   logic [RemW-1:0]         s_ff, s_in, root_ff, root_in;
   logic [DivW-1:0]         dv_ff, dv_in;
   logic [QuotW-1:0]        q_ff, q_in, q_next;
   logic signed [FieldW-1:0] rslt_ff [2][3], rslt_in [2][3];
   logic                    deg_ff [2], deg_in [2];
   logic [4:0]              cnt_ff, cnt_in;
   logic [1:0]              comp_ff, comp_in;
   logic                    sel_ff, sel_in;
   logic [FieldW-1:0]       out_ff [6];
   logic                    outdeg_ff [2];

   logic signed [MulW-1:0]  mul_a, mul_b;
   logic [RemW-1:0]         sub_a, sub_b;
   logic [RemW:0]           sub_d;
   logic                    borrow;
   logic [4:0]              prod_idx;
   logic                    mag_hi, vec_zero, k_neg, k_zero;
   logic signed [VecW-1:0]  pick [3];

   // input fields as coordinates
   assign cur[0] = take_coord(req_pos_x);
   assign cur[1] = take_coord(req_pos_y);
   assign cur[2] = take_coord(req_pos_z);
   assign cur[3] = take_coord(req_tex_u);
   assign cur[4] = take_coord(req_tex_v);

   // handshake and writeback control
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && (state_ff == ST_IDLE);
      out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // shared multiplier operands
   assign prod_idx = cnt_ff;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         case (prod_idx)
            5'd0:  begin mul_a = MulW'(t1_ff);    mul_b = MulW'(b2_ff);    end
            5'd1:  begin mul_a = MulW'(b1_ff);    mul_b = MulW'(t2_ff);    end
            5'd2:  begin mul_a = MulW'(b2_ff);    mul_b = MulW'(e0_ff[0]); end
            5'd3:  begin mul_a = MulW'(b1_ff);    mul_b = MulW'(e1_ff[0]); end
            5'd4:  begin mul_a = MulW'(b2_ff);    mul_b = MulW'(e0_ff[1]); end
            5'd5:  begin mul_a = MulW'(b1_ff);    mul_b = MulW'(e1_ff[1]); end
            5'd6:  begin mul_a = MulW'(b2_ff);    mul_b = MulW'(e0_ff[2]); end
            5'd7:  begin mul_a = MulW'(b1_ff);    mul_b = MulW'(e1_ff[2]); end
            5'd8:  begin mul_a = MulW'(e0_ff[1]); mul_b = MulW'(e1_ff[2]); end
            5'd9:  begin mul_a = MulW'(e0_ff[2]); mul_b = MulW'(e1_ff[1]); end
            5'd10: begin mul_a = MulW'(e0_ff[2]); mul_b = MulW'(e1_ff[0]); end
            5'd11: begin mul_a = MulW'(e0_ff[0]); mul_b = MulW'(e1_ff[2]); end
            5'd12: begin mul_a = MulW'(e0_ff[0]); mul_b = MulW'(e1_ff[1]); end
            5'd13: begin mul_a = MulW'(e0_ff[1]); mul_b = MulW'(e1_ff[0]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == ST_SQ && cnt_ff < 5'(SqLast)) begin
         mul_a = {1'b0, mag31[cnt_ff[1:0]]};
         mul_b = {1'b0, mag31[cnt_ff[1:0]]};
      end
   end

   // shared subtractor for root and divide steps
   always_comb begin
      sub_a = s_ff;
      sub_b = '0;
      if (state_ff == ST_ROOT) begin
         sub_b = root_ff + (RemW'(1) << {cnt_ff, 1'b0});
      end else if (state_ff == ST_DIV) begin
         sub_b = RemW'(dv_ff);
      end
      sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
      borrow = sub_d[RemW];
      q_next = {q_ff[QuotW-2:0], ~borrow};
   end

   // vector picked for normalization, with the sign of k on the tangent
   always_comb begin
      k_neg  = vec_ff[0][VecW-1];
      k_zero = (vec_ff[0] == '0);
      mag_hi = 1'b0;
      for (int i = 0; i < 3; i++) begin
         pick[i]  = sel_ff ? vec_ff[1+i] : vec_ff[4+i];
         mag31[i] = MagW'(mag_ff[i]);
         mag_hi   = mag_hi | ((mag_ff[i] >> MagW) != '0);
      end
      vec_zero = (pick[0] == '0) && (pick[1] == '0) && (pick[2] == '0);
      vec_zero = vec_zero || (sel_ff && k_zero);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (accept && count_ff == 2'd2) state_in = ST_MUL;
         ST_MUL:     if (cnt_ff == 5'(ProdLast)) state_in = ST_LOAD;
         ST_LOAD: begin
            if (!vec_zero) state_in = ST_SHIFT;
            else if (sel_ff) state_in = ST_DONE;
         end
         ST_SHIFT:   if (!mag_hi) state_in = ST_SQ;
         ST_SQ:      if (cnt_ff == 5'(SqLast)) state_in = ST_ROOT;
         ST_ROOT:    if (cnt_ff == '0) state_in = ST_DIVINIT;
         ST_DIVINIT: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == '0) begin
               if (comp_ff != 2'd2) state_in = ST_DIVINIT;
               else if (sel_ff) state_in = ST_DONE;
               else state_in = ST_LOAD;
            end
         end
         ST_DONE:    if (out_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // corner count and output valid
   always_comb begin
      count_in = count_ff;
      if (accept) count_in = (count_ff == 2'd2) ? 2'd0 : count_ff + 2'd1;
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // datapath next values
   always_comb begin
      held_in = held_ff;
      e0_in = e0_ff;
      e1_in = e1_ff;
      t1_in = t1_ff;
      b1_in = b1_ff;
      t2_in = t2_ff;
      b2_in = b2_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      vec_in = vec_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      s_in = s_ff;
      root_in = root_ff;
      dv_in = dv_ff;
      q_in = q_ff;
      rslt_in = rslt_ff;
      deg_in = deg_ff;
      cnt_in = cnt_ff;
      comp_in = comp_ff;
      sel_in = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff != 2'd2) begin
                  held_in[count_ff[0]] = cur;
               end else begin
                  // edges and texture deltas from the first corner
                  for (int i = 0; i < 3; i++) begin
                     e0_in[i] = scaled_diff(held_ff[1][i], held_ff[0][i]);
                     e1_in[i] = scaled_diff(cur[i], held_ff[0][i]);
                  end
                  t1_in = scaled_diff(held_ff[1][3], held_ff[0][3]);
                  b1_in = scaled_diff(held_ff[1][4], held_ff[0][4]);
                  t2_in = scaled_diff(cur[3], held_ff[0][3]);
                  b2_in = scaled_diff(cur[4], held_ff[0][4]);
                  cnt_in = '0;
                  sel_in = 1'b0;
               end
            end
         end
         ST_MUL: begin
            // product of this step is registered, each pair's difference is formed from the registered products
            prod_in = mul_a * mul_b;
            if (cnt_ff != '0) begin
               if (cnt_ff[0]) acc_in = prod_ff;
               else vec_in[3'((cnt_ff - 5'd1) >> 1)] = VecW'(acc_ff - prod_ff);
            end
            cnt_in = cnt_ff + 5'd1;
         end
         ST_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = pick[i][VecW-1] ^ (sel_ff & k_neg);
               mag_in[i] = pick[i][VecW-1] ? VecW'(-pick[i]) : pick[i];
            end
            deg_in[sel_ff] = vec_zero;
            if (vec_zero) begin
               for (int i = 0; i < 3; i++) rslt_in[sel_ff][i] = '0;
               sel_in = 1'b1;
            end
         end
         ST_SHIFT: begin
            if (mag_hi) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else begin
               cnt_in = '0;
            end
         end
         ST_SQ: begin
            // sum of squares
            prod_in = mul_a * mul_b;
            if (cnt_ff == 5'd1) s_in = prod_ff;
            else if (cnt_ff != '0) s_in = s_ff + prod_ff;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SqLast)) begin
               cnt_in = 5'(RootFirst);
               root_in = '0;
            end
         end
         ST_ROOT: begin
            // one root bit per step
            if (!borrow) begin
               s_in = sub_d[RemW-1:0];
               root_in = (root_ff >> 1) + (RemW'(1) << {cnt_ff, 1'b0});
            end else begin
               root_in = root_ff >> 1;
            end
            cnt_in = cnt_ff - 5'd1;
            comp_in = '0;
         end
         ST_DIVINIT: begin
            s_in = RemW'({mag31[comp_ff], FracBits'(0)}) + RemW'(root_ff[MulW-1:1]);
            dv_in = {root_ff[MulW-1:0], FracBits'(0)};
            q_in = '0;
            cnt_in = 5'(FracBits);
         end
         ST_DIV: begin
            // one quotient bit per step
            if (!borrow) s_in = sub_d[RemW-1:0];
            dv_in = dv_ff >> 1;
            q_in = q_next;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               rslt_in[sel_ff][comp_ff] = neg_ff[comp_ff] ? -FieldW'(q_next)
                                                          : FieldW'(q_next);
               comp_in = comp_ff + 2'd1;
               if (comp_ff == 2'd2) sel_in = 1'b1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      held_ff <= held_in;
      e0_ff <= e0_in;
      e1_ff <= e1_in;
      t1_ff <= t1_in;
      b1_ff <= b1_in;
      t2_ff <= t2_in;
      b2_ff <= b2_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      vec_ff <= vec_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      s_ff <= s_in;
      root_ff <= root_in;
      dv_ff <= dv_in;
      q_ff <= q_in;
      rslt_ff <= rslt_in;
      deg_ff <= deg_in;
      cnt_ff <= cnt_in;
      comp_ff <= comp_in;
      sel_ff <= sel_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= rslt_ff[0][i];
            out_ff[3+i] <= rslt_ff[1][i];
         end
         outdeg_ff <= deg_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_normal_x           = out_ff[0];
   assign rsp_normal_y           = out_ff[1];
   assign rsp_normal_z           = out_ff[2];
   assign rsp_tangent_x          = out_ff[3];
   assign rsp_tangent_y          = out_ff[4];
   assign rsp_tangent_z          = out_ff[5];
   assign rsp_normal_degenerate  = outdeg_ff[0];
   assign rsp_tangent_degenerate = outdeg_ff[1];

   // a new result only comes from the writeback state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result valid without writeback");

   // the corner count never passes the third corner
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("corner count out of range");

   // a degenerate normal is all zero
   a_normal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_normal_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate normal not zero");

   // the product phase is entered only from an accepted item or from itself
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> $past(accept) || $past(state_ff == ST_MUL))
      else $error("product phase entered without a third corner");

endmodule
`default_nettype wire

>>> tb/sv/triangle_normal_tangent_unit_tb.sv
// testbench for the triangle normal and tangent unit: directed and random vertices, predicted normals and tangents
`timescale 1ns / 100ps
`default_nettype none
module triangle_normal_tangent_unit_tb;

   localparam int CW = tnt_pkg::CoordWidthDefault;
   localparam int DiffShift = (CW > 30) ? CW - 30 : 0;
   localparam int NumRandom = 1100;
   localparam longint CycleLimit = 2000000;

   typedef struct packed {
      logic [15:0] pos_x, pos_y, pos_z, tex_u, tex_v;
   } vertex_type;

   typedef struct packed {
      logic [15:0] nx, ny, nz, tx, ty, tz;
      logic        ndeg, tdeg;
   } shading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [15:0] req_tex_u = '0, req_tex_v = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [15:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic rsp_normal_degenerate, rsp_tangent_degenerate;

   triangle_normal_tangent_unit #(.COORD_WIDTH(CW)) u_dut (.*);

   vertex_type  vertex_queue[$];
   shading_type shading_queue[$];
   vertex_type  corner_store[2];
   int       corner_cnt = 0;
   int       mismatch_cnt = 0;
   int       result_cnt = 0;
   int       degen_cnt = 0;
   longint   cycle_cnt = 0;
   bit       stim_done = 1'b0;
   bit       hold_off = 1'b0;
   int       burst_left = 0;
   int       gap_left = 0;
   int       stall_mode = 0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint sext(logic [15:0] raw);
      logic [CW-1:0] low;
      low = raw[CW-1:0];
      return longint'($signed(low));
   endfunction

   function automatic longint edge_diff(longint a, longint b);
      longint d;
      longint m;
      d = a - b;
      m = (d < 0) ? -d : d;
      m = m >>> DiffShift;
      return (d < 0) ? -m : m;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // scale a vector to unit length in Q1.14, returns 1 for the zero vector
   function automatic bit to_unit(input longint v[3], output logic [15:0] r[3]);
      longint unsigned m[3];
      longint unsigned mx, s, len, q;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (v[i] < 0) ? -v[i] : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) r[i] = '0;
         return 1'b1;
      end
      while (mx >= (64'd1 << 31)) begin
         mx = mx >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      for (int i = 0; i < 3; i++) s += m[i] * m[i];
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 14) + (len >> 1)) / len;
         r[i] = (v[i] < 0) ? 16'(-longint'(q)) : 16'(q);
      end
      return 1'b0;
   endfunction

   // track corners and predict the shading of each completed triangle
   task automatic predict_vertex(vertex_type vx);
      longint c0[5], c1[5], c2[5];
      longint e0[3], e1[3], nv[3], tv[3];
      longint t1, b1, t2, b2, k, cr;
      logic [15:0] nr[3], tr[3];
      shading_type res;
      if (corner_cnt < 2) begin
         corner_store[corner_cnt] = vx;
         corner_cnt++;
         return;
      end
      corner_cnt = 0;
      c0 = '{sext(corner_store[0].pos_x), sext(corner_store[0].pos_y),
             sext(corner_store[0].pos_z), sext(corner_store[0].tex_u),
             sext(corner_store[0].tex_v)};
      c1 = '{sext(corner_store[1].pos_x), sext(corner_store[1].pos_y),
             sext(corner_store[1].pos_z), sext(corner_store[1].tex_u),
             sext(corner_store[1].tex_v)};
      c2 = '{sext(vx.pos_x), sext(vx.pos_y), sext(vx.pos_z), sext(vx.tex_u), sext(vx.tex_v)};
      for (int i = 0; i < 3; i++) begin
         e0[i] = edge_diff(c1[i], c0[i]);
         e1[i] = edge_diff(c2[i], c0[i]);
      end
      t1 = edge_diff(c1[3], c0[3]);
      b1 = edge_diff(c1[4], c0[4]);
      t2 = edge_diff(c2[3], c0[3]);
      b2 = edge_diff(c2[4], c0[4]);
      k = t1 * b2 - b1 * t2;
      for (int i = 0; i < 3; i++) begin
         cr = b2 * e0[i] - b1 * e1[i];
         tv[i] = (k < 0) ? -cr : cr;
      end
      nv[0] = e0[1] * e1[2] - e0[2] * e1[1];
      nv[1] = e0[2] * e1[0] - e0[0] * e1[2];
      nv[2] = e0[0] * e1[1] - e0[1] * e1[0];
      res.ndeg = to_unit(nv, nr);
      if (k == 0) begin
         tr = '{16'd0, 16'd0, 16'd0};
         res.tdeg = 1'b1;
      end else begin
         res.tdeg = to_unit(tv, tr);
      end
      {res.nx, res.ny, res.nz} = {nr[0], nr[1], nr[2]};
      {res.tx, res.ty, res.tz} = {tr[0], tr[1], tr[2]};
      shading_queue = {shading_queue, res};
   endtask

   function automatic vertex_type rand_vertex();
      vertex_type vx;
      vx = vertex_type'(80'({$urandom, $urandom, $urandom}));
      return vx;
   endfunction

   // vertex near a base point, so edges stay short and sometimes collinear
   function automatic vertex_type near_vertex(vertex_type base, int spread);
      vertex_type vx;
      vx.pos_x = base.pos_x + 16'($urandom_range(0, 2 * spread) - spread);
      vx.pos_y = base.pos_y + 16'($urandom_range(0, 2 * spread) - spread);
      vx.pos_z = base.pos_z + 16'($urandom_range(0, 2 * spread) - spread);
      vx.tex_u = base.tex_u + 16'($urandom_range(0, 2 * spread) - spread);
      vx.tex_v = base.tex_v + 16'($urandom_range(0, 2 * spread) - spread);
      return vx;
   endfunction

   task automatic add_tri(vertex_type a, vertex_type b, vertex_type c);
      vertex_queue = {vertex_queue, a, b, c};
   endtask

   // stimulus
   initial begin
      vertex_type a, b, c, mx, mn;
      int sel;
      mx = {5{16'h7fff}};
      mn = {5{16'h8000}};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed: unit axes, extremes, all three corners equal, collinear, zero k
      add_tri('0, {16'h1000, 64'h0}, {16'h0, 16'h1000, 16'h0, 16'h1000, 16'h1000});
      add_tri(mn, mx, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
      add_tri(mx, mn, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
      add_tri(mx, mx, mx);
      add_tri('0, {16'h0100, 16'h0100, 16'h0100, 16'h0, 16'h0},
              {16'h0200, 16'h0200, 16'h0200, 16'h0, 16'h0});
      add_tri('0, {16'h1000, 16'h0, 16'h0, 16'h1000, 16'h1000},
              {16'h0, 16'h1000, 16'h0, 16'h2000, 16'h2000});
      add_tri({16'h8000, 16'h0, 16'h7fff, 16'hffff, 16'h0001},
              {16'h7fff, 16'h8000, 16'h0, 16'h0001, 16'hffff},
              {16'h0, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
      add_tri('1, '0, {16'h0001, 16'hffff, 16'h0, 16'hffff, 16'h0001});
      wait (vertex_queue.size() == 0);
      // pause until every result is back
      hold_off = 1'b1;
      wait (shading_queue.size() == 0 && corner_cnt == 0);
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
      // random triangles, mostly well formed with local geometry
      for (int i = 0; i < NumRandom / 3; i++) begin
         sel = $urandom_range(0, 9);
         a = rand_vertex();
         if (sel < 4) begin
            add_tri(a, rand_vertex(), rand_vertex());
         end else if (sel < 8) begin
            add_tri(a, near_vertex(a, 300), near_vertex(a, 300));
         end else begin
            b = near_vertex(a, 2);
            c = near_vertex(a, 2);
            if (sel == 9) c = b;
            add_tri(a, b, c);
         end
         while (vertex_queue.size() > 30) @(posedge clock);
      end
      wait (vertex_queue.size() == 0);
      stim_done = 1'b1;
   end

   // driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) predict_vertex({req_pos_x, req_pos_y, req_pos_z, req_tex_u, req_tex_v});
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (vertex_queue.size() > 0 && !hold_off) begin
            {req_pos_x, req_pos_y, req_pos_z, req_tex_u, req_tex_v} <= vertex_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, changes mode now and then
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (cycle_cnt[5:3] == 3'd0);
      endcase
   end

   // monitor
   always @(posedge clock) begin
      shading_type got, exp_res;
      cycle_cnt <= cycle_cnt + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_tangent_x, rsp_tangent_y,
                rsp_tangent_z, rsp_normal_degenerate, rsp_tangent_degenerate};
         result_cnt++;
         if (got.ndeg || got.tdeg) degen_cnt++;
         if (shading_queue.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("unexpected result %h", got);
         end else begin
            exp_res = shading_queue.pop_front();
            if (got !== exp_res) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mismatch: exp n=%0d,%0d,%0d t=%0d,%0d,%0d d=%b%b got n=%0d,%0d,%0d t=%0d,%0d,%0d d=%b%b",
                     $signed(exp_res.nx), $signed(exp_res.ny), $signed(exp_res.nz),
                     $signed(exp_res.tx), $signed(exp_res.ty), $signed(exp_res.tz),
                     exp_res.ndeg, exp_res.tdeg,
                     $signed(got.nx), $signed(got.ny), $signed(got.nz),
                     $signed(got.tx), $signed(got.ty), $signed(got.tz), got.ndeg, got.tdeg);
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done && !req_valid && shading_queue.size() == 0);
      repeat (400) @(posedge clock);
      $display("covered %0d triangles, %0d with a degenerate vector", result_cnt, degen_cnt);
      if (mismatch_cnt == 0 && shading_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_cnt, shading_queue.size());
         $display("status: fail");
      end
      $finish;
   end

   // timeout
   initial begin
      wait (cycle_cnt >= CycleLimit);
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
rtl/tnt_pkg.sv
rtl/triangle_normal_tangent_unit.sv
tb/sv/triangle_normal_tangent_unit_tb.sv
